FILE: hw/rtl/pkcs1_pkg.sv
// shared types and constants for the pkcs1 v1.5 padding core
package pkcs1_pkg;

    localparam int MAX_EM_BYTES = 512;
    localparam int MAX_PAYLOAD  = 64;
    localparam int PL_AW        = $clog2(MAX_PAYLOAD);
    localparam int OID_MAX      = 9;

    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 9;
    localparam int BYTE_W     = 8;
    localparam int EM_LEN_W   = 10;
    localparam int PL_LEN_W   = 7;
    localparam int OID_LEN_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [BYTE_W-1:0] DER_SEQ    = 8'h30;
    localparam logic [BYTE_W-1:0] DER_OID    = 8'h06;
    localparam logic [BYTE_W-1:0] DER_NULL   = 8'h05;
    localparam logic [BYTE_W-1:0] DER_OCTETS = 8'h04;
    localparam logic [BYTE_W-1:0] SEQ_EXTRA  = 8'h08;
    localparam logic [BYTE_W-1:0] ALG_EXTRA  = 8'h04;
    localparam logic [BYTE_W-1:0] DER_OVHD   = 8'd10;
    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] BT_BYTE    = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_READ = 2'd1,
        CMD_CMP  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EM_LEN    = 3'd0,
        CFG_DER_MODE  = 3'd1,
        CFG_PL_LEN    = 3'd2,
        CFG_OID_LEN   = 3'd3,
        CFG_OID_FIRST = 3'd4,
        CFG_OID_LAST  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [EM_LEN_W-1:0]   em_len;
        logic                  der_mode;
        logic [PL_LEN_W-1:0]   payload_len;
        logic [OID_LEN_W-1:0]  oid_len;
        logic [63:0]           oid_first_bytes;
        logic [BYTE_W-1:0]     oid_last_byte;
    } t_cfg;

    typedef struct packed {
        logic              bad;
        logic              valid;
        logic [BYTE_W-1:0] em;
    } t_exp;

endpackage

FILE: hw/rtl/pkcs1_in_if.sv
// request channel: command, position and data byte
interface pkcs1_in_if
    import pkcs1_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;

    modport source (output valid, output cmd, output index, output data, input ready);
    modport sink   (input valid, input cmd, input index, input data, output ready);
endinterface

FILE: hw/rtl/pkcs1_out_if.sv
// result channel: expected byte and status flags
interface pkcs1_out_if
    import pkcs1_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] em_byte;
    logic              all_match;
    logic              length_error;

    modport source (output valid, output em_byte, output all_match, output length_error,
                    input ready);
    modport sink   (input valid, input em_byte, input all_match, input length_error,
                    output ready);
endinterface

FILE: hw/rtl/pkcs1_ram.sv
// generic single-write, single-read ram with registered read data
module pkcs1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/pkcs1_expect.sv
// expected encoded byte at a position: 00 01 ff..ff 00 t
module pkcs1_expect
    import pkcs1_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic [INDEX_W-1:0] i_pos,
    input  logic [BYTE_W-1:0]  i_payload,
    output t_exp               o_exp
);
    logic [BYTE_W-1:0]   w_oid8;
    logic [BYTE_W-1:0]   w_pl8;
    logic [BYTE_W-1:0]   w_tl;
    logic [EM_LEN_W-1:0] w_t_start;
    logic [EM_LEN_W-1:0] w_pos;
    logic [BYTE_W-1:0]   w_q;
    logic [BYTE_W-1:0]   w_k;
    logic [BYTE_W-1:0]   w_r;
    logic [2:0]          w_oid_sel;
    logic [BYTE_W-1:0]   w_oid_byte;
    logic                w_bad;
    logic [BYTE_W-1:0]   w_byte;

    assign w_oid8    = BYTE_W'(i_cfg.oid_len);
    assign w_pl8     = BYTE_W'(i_cfg.payload_len);
    assign w_tl      = i_cfg.der_mode ? (DER_OVHD + w_oid8 + w_pl8) : w_pl8;
    assign w_t_start = i_cfg.em_len - EM_LEN_W'(w_tl);
    assign w_pos     = EM_LEN_W'(i_pos);
    assign w_q       = BYTE_W'(w_pos - w_t_start);
    assign w_k       = w_q - BYTE_W'(6);
    assign w_r       = w_k - w_oid8;
    assign w_oid_sel = 3'd7 - w_k[2:0];
    assign w_oid_byte = (w_k[3]) ? i_cfg.oid_last_byte
                                 : i_cfg.oid_first_bytes[{w_oid_sel, 3'b000} +: BYTE_W];

    assign w_bad = ({1'b0, i_cfg.em_len} > 11'(MAX_EM_BYTES))
                || ({1'b0, i_cfg.payload_len} > 8'(MAX_PAYLOAD))
                || (i_cfg.der_mode && (i_cfg.oid_len > OID_LEN_W'(OID_MAX)))
                || ({1'b0, i_cfg.em_len} < (11'd3 + 11'(w_tl)));

    always_comb begin
        w_byte = '0;
        if (w_pos == '0) begin
            w_byte = '0;
        end else if (w_pos == EM_LEN_W'(1)) begin
            w_byte = BT_BYTE;
        end else if (w_pos < w_t_start - EM_LEN_W'(1)) begin
            w_byte = PAD_BYTE;
        end else if (w_pos == w_t_start - EM_LEN_W'(1)) begin
            w_byte = '0;
        end else if (!i_cfg.der_mode) begin
            w_byte = i_payload;
        end else if (w_q == 8'd0 || w_q == 8'd2) begin
            w_byte = DER_SEQ;
        end else if (w_q == 8'd1) begin
            w_byte = SEQ_EXTRA + w_oid8 + w_pl8;
        end else if (w_q == 8'd3) begin
            w_byte = ALG_EXTRA + w_oid8;
        end else if (w_q == 8'd4) begin
            w_byte = DER_OID;
        end else if (w_q == 8'd5) begin
            w_byte = w_oid8;
        end else if (w_k < w_oid8) begin
            w_byte = w_oid_byte;
        end else begin
            // tail after the oid: null, octet string header, digest
            case (w_r)
                8'd0:    w_byte = DER_NULL;
                8'd1:    w_byte = '0;
                8'd2:    w_byte = DER_OCTETS;
                8'd3:    w_byte = w_pl8;
                default: w_byte = i_payload;
            endcase
        end
    end

    assign o_exp.bad   = w_bad;
    assign o_exp.valid = !w_bad && (w_pos < i_cfg.em_len);
    assign o_exp.em    = o_exp.valid ? w_byte : '0;
endmodule

FILE: hw/rtl/pkcs1_v15_signature_padding_core.sv
// top level of the pkcs1 v1.5 signature padding builder and checker
//
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   cmd, index, data
//  o_out     out  valid/ready   em_byte, all_match, length_error
//  i_cfg_*   in   write enable  register index, write data
//
//  one transaction per cycle sustained while the output is not stalled;
//  the payload ram read issued at accept is registered, and its data is
//  used in the working stage with the match flag read-modify-write
//  a stalled output holds the working stage, which then holds off the input
//  reset restores the config defaults and sets the match flag; payload ram
//  is not cleared
module pkcs1_v15_signature_padding_core
    import pkcs1_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pkcs1_in_if.sink              i_in,
    pkcs1_out_if.source           o_out
);
    t_cfg               r_cfg;
    logic               r_busy;
    t_cmd               r_cmd;
    logic [INDEX_W-1:0] r_idx;
    logic [BYTE_W-1:0]  r_data;
    logic               r_match;
    logic               n_match;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_em;
    logic               r_out_match;
    logic               r_out_lerr;

    logic               w_accept;
    logic               w_adv;
    logic               w_load;
    logic [PL_AW-1:0]   w_raddr;
    logic [BYTE_W-1:0]  w_rdata;
    t_exp               w_exp;
    logic [BYTE_W-1:0]  w_em;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.em_len          <= EM_LEN_W'(256);
            r_cfg.der_mode        <= 1'b1;
            r_cfg.payload_len     <= PL_LEN_W'(32);
            r_cfg.oid_len         <= OID_LEN_W'(9);
            r_cfg.oid_first_bytes <= '0;
            r_cfg.oid_last_byte   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EM_LEN:    r_cfg.em_len          <= i_cfg_data[EM_LEN_W-1:0];
                CFG_DER_MODE:  r_cfg.der_mode        <= i_cfg_data[0];
                CFG_PL_LEN:    r_cfg.payload_len     <= i_cfg_data[PL_LEN_W-1:0];
                CFG_OID_LEN:   r_cfg.oid_len         <= i_cfg_data[OID_LEN_W-1:0];
                CFG_OID_FIRST: r_cfg.oid_first_bytes <= i_cfg_data;
                CFG_OID_LAST:  r_cfg.oid_last_byte   <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv      = r_busy && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_busy || w_adv;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = w_accept && (t_cmd'(i_in.cmd) == CMD_LOAD)
                     && (i_in.index < INDEX_W'(MAX_PAYLOAD));

    // payload bytes sit at the tail of the message in both modes
    assign w_raddr = i_in.index[PL_AW-1:0] - r_cfg.em_len[PL_AW-1:0]
                   + r_cfg.payload_len[PL_AW-1:0];

    pkcs1_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_in.index[PL_AW-1:0]),
        .i_wdata (i_in.data),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pkcs1_expect u_expect (
        .i_cfg     (r_cfg),
        .i_pos     (r_idx),
        .i_payload (w_rdata),
        .o_exp     (w_exp)
    );

    assign w_em = (r_cmd == CMD_READ || r_cmd == CMD_CMP) ? w_exp.em : '0;

    always_comb begin
        n_match = r_match;
        if (r_cmd == CMD_CMP) begin
            n_match = ((r_idx == '0) || r_match) && w_exp.valid && (w_exp.em == r_data);
        end
    end

    // working stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_adv) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= t_cmd'(i_in.cmd);
            r_idx  <= i_in.index;
            r_data <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
        end else if (w_adv) begin
            r_match <= n_match;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_em    <= w_em;
            r_out_match <= n_match;
            r_out_lerr  <= w_exp.bad;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.em_byte      = r_out_em;
    assign o_out.all_match    = r_out_match;
    assign o_out.length_error = r_out_lerr;

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !w_adv |=> r_busy && $stable(r_idx) && $stable(r_cmd))
        else $error("working stage lost its transaction while stalled");

    a_match_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_match && !(w_adv && r_cmd == CMD_CMP && r_idx == '0) |=> !r_match)
        else $error("match flag set without a compare at position zero");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.length_error |-> o_out.em_byte == '0)
        else $error("nonzero byte reported with a length error");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_em))
        else $error("pending result overwritten");
endmodule

FILE: test/pkcs1_v15_signature_padding_core_test.sv
`timescale 1ns / 100ps
// testbench for the pkcs1 v1.5 padding core: directed table, then random phases checked by a predictor
module pkcs1_v15_signature_padding_core_test
    import pkcs1_pkg::*;
;

    localparam int ITEM_TARGET  = 1850;
    localparam int QUIET_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_MAX     = 19;

    typedef struct packed {
        logic [BYTE_W-1:0] em_byte;
        logic              all_match;
        logic              length_error;
    } t_em_result;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_REQ_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_cmd                  cmd;
        logic [INDEX_W-1:0]    index;
        logic [BYTE_W-1:0]     data;
        t_em_result            res;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pkcs1_in_if  in_ch ();
    pkcs1_out_if out_ch ();

    pkcs1_v15_signature_padding_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_cfg              pred_cfg;
    logic [BYTE_W-1:0] pred_payload [MAX_PAYLOAD];
    logic              pred_match;

    t_em_result expected_em_q [$];
    t_em_result want_res;

    int n_errors       = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_phases       = 0;
    int n_bad_phases   = 0;
    int n_clean_sweeps = 0;
    int cycle_count    = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;

    function automatic int digest_info_len(t_cfg c);
        if (c.der_mode)
            return int'(DER_OVHD) + int'(c.oid_len) + int'(c.payload_len);
        return int'(c.payload_len);
    endfunction

    function automatic bit config_unusable();
        if (int'(pred_cfg.em_len) > MAX_EM_BYTES || int'(pred_cfg.payload_len) > MAX_PAYLOAD)
            return 1'b1;
        if (pred_cfg.der_mode && int'(pred_cfg.oid_len) > OID_MAX)
            return 1'b1;
        return int'(pred_cfg.em_len) < 3 + digest_info_len(pred_cfg);
    endfunction

    function automatic logic [BYTE_W-1:0] payload_at(int k);
        if (k < MAX_PAYLOAD)
            return pred_payload[k];
        return 8'h00;
    endfunction

    // byte p of 00 01 ff..ff 00 T, config known good and p inside the message
    function automatic logic [BYTE_W-1:0] encoded_byte_at(int p);
        int ps;
        int q;
        int oid;
        int pl;
        oid = int'(pred_cfg.oid_len);
        pl  = int'(pred_cfg.payload_len);
        ps  = int'(pred_cfg.em_len) - 3 - digest_info_len(pred_cfg);
        if (p == 0)
            return 8'h00;
        if (p == 1)
            return BT_BYTE;
        if (p < 2 + ps)
            return PAD_BYTE;
        if (p == 2 + ps)
            return 8'h00;
        q = p - 3 - ps;
        if (!pred_cfg.der_mode)
            return payload_at(q);
        if (q == 0 || q == 2)
            return DER_SEQ;
        if (q == 1)
            return 8'(int'(SEQ_EXTRA) + oid + pl);
        if (q == 3)
            return 8'(int'(ALG_EXTRA) + oid);
        if (q == 4)
            return DER_OID;
        if (q == 5)
            return 8'(oid);
        if (q < 6 + oid) begin
            if (q - 6 < 8)
                return pred_cfg.oid_first_bytes[63 - 8 * (q - 6) -: 8];
            return pred_cfg.oid_last_byte;
        end
        q -= 6 + oid;
        if (q == 0)
            return DER_NULL;
        if (q == 1)
            return 8'h00;
        if (q == 2)
            return DER_OCTETS;
        if (q == 3)
            return 8'(pl);
        return payload_at(q - 4);
    endfunction

    function automatic t_em_result encode_step(t_cmd cmd, int idx, int data);
        t_em_result r;
        bit         bad;
        bit         hit;
        bad = config_unusable();
        hit = 1'b0;
        r.em_byte = 8'h00;
        case (cmd)
            CMD_LOAD: begin
                if (idx < MAX_PAYLOAD)
                    pred_payload[idx] = 8'(data);
            end
            CMD_READ, CMD_CMP: begin
                if (!bad && idx < int'(pred_cfg.em_len)) begin
                    r.em_byte = encoded_byte_at(idx);
                    hit = 1'b1;
                end
                if (cmd == CMD_CMP) begin
                    if (idx == 0)
                        pred_match = 1'b1;
                    if (!hit || int'(r.em_byte) != data)
                        pred_match = 1'b0;
                end
            end
            default: ;
        endcase
        r.all_match    = pred_match;
        r.length_error = bad;
        return r;
    endfunction

    function automatic t_cfg pick_config(bit unusable);
        t_cfg c;
        int   tl;
        c.der_mode = 1'($urandom_range(0, 1));
        c.oid_len  = OID_LEN_W'(c.der_mode ? $urandom_range(0, OID_MAX) : $urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0:       c.payload_len = '0;
            1:       c.payload_len = PL_LEN_W'(MAX_PAYLOAD);
            default: c.payload_len = PL_LEN_W'($urandom_range(1, 40));
        endcase
        c.oid_first_bytes = {$urandom, $urandom};
        c.oid_last_byte   = 8'($urandom);
        tl = digest_info_len(c);
        if ($urandom_range(0, 9) == 0)
            c.em_len = EM_LEN_W'(3 + tl + $urandom_range(0, MAX_EM_BYTES - 3 - tl));
        else
            c.em_len = EM_LEN_W'(3 + tl + $urandom_range(0, 16));
        if (unusable) begin
            case ($urandom_range(0, 3))
                0: c.em_len = EM_LEN_W'(2 + tl);
                1: c.payload_len = PL_LEN_W'($urandom_range(MAX_PAYLOAD + 1, 127));
                2: begin
                    c.der_mode = 1'b1;
                    c.oid_len  = OID_LEN_W'($urandom_range(OID_MAX + 1, 15));
                end
                default: c.em_len = EM_LEN_W'($urandom_range(MAX_EM_BYTES + 1, 1023));
            endcase
        end
        return c;
    endfunction

    // one request transaction, with an optional idle burst in front of it
    task automatic send_request(t_cmd cmd, int idx, int data, bit typed, t_em_result typed_res);
        t_em_result r;
        // the tail of the run goes without idling on either side
        if (n_items > ITEM_TARGET - QUIET_ITEMS) begin
            gap_pct   = 0;
            stall_pct = 0;
        end
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.index <= INDEX_W'(idx);
        in_ch.data  <= BYTE_W'(data);
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        r = encode_step(cmd, idx, data);
        if (typed)
            r = typed_res;
        expected_em_q.push_back(r);
        if (cmd != CMD_NONE && !(cmd == CMD_LOAD && idx >= MAX_PAYLOAD))
            n_items++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_em_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_EM_LEN:    pred_cfg.em_len          = val[EM_LEN_W-1:0];
            CFG_DER_MODE:  pred_cfg.der_mode        = val[0];
            CFG_PL_LEN:    pred_cfg.payload_len     = val[PL_LEN_W-1:0];
            CFG_OID_LEN:   pred_cfg.oid_len         = val[OID_LEN_W-1:0];
            CFG_OID_FIRST: pred_cfg.oid_first_bytes = val;
            CFG_OID_LAST:  pred_cfg.oid_last_byte   = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_registers(t_cfg c);
        set_register(CFG_EM_LEN, CFG_DATA_W'(c.em_len));
        set_register(CFG_DER_MODE, CFG_DATA_W'(c.der_mode));
        set_register(CFG_PL_LEN, CFG_DATA_W'(c.payload_len));
        set_register(CFG_OID_LEN, CFG_DATA_W'(c.oid_len));
        set_register(CFG_OID_FIRST, c.oid_first_bytes);
        set_register(CFG_OID_LAST, CFG_DATA_W'(c.oid_last_byte));
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stall bursts
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, IDLE_MAX)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_em_q.size() == 0) begin
                $error("result transaction with no request pending");
                n_errors++;
            end else begin
                want_res = expected_em_q.pop_front();
                n_results++;
                if (out_ch.em_byte !== want_res.em_byte) begin
                    $error("em_byte: expected %02h, got %02h", want_res.em_byte, out_ch.em_byte);
                    n_errors++;
                end
                if (out_ch.all_match !== want_res.all_match) begin
                    $error("all_match: expected %0b, got %0b", want_res.all_match,
                           out_ch.all_match);
                    n_errors++;
                end
                if (out_ch.length_error !== want_res.length_error) begin
                    $error("length_error: expected %0b, got %0b", want_res.length_error,
                           out_ch.length_error);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_directed_row directed_rows [] = '{
        // defaults after reset: der, em 256, payload 32, oid 9 zero bytes
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd0,   8'h00, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd1,   8'h00, '{8'h01, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd2,   8'h00, '{8'hFF, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd204, 8'h00, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd206, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_NONE, 9'd511, 8'hFF, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_LOAD, 9'd63,  8'hFF, '{8'h00, 1'b1, 1'b0}},
        // load past the store is dropped, payload byte 0 must survive
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_LOAD, 9'd64,  8'h5A, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd224, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd256, 8'h00, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_CMP,  9'd0,   8'h00, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_CMP,  9'd1,   8'h01, '{8'h01, 1'b1, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_CMP,  9'd2,   8'h00, '{8'hFF, 1'b0, 1'b0}},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_CMP,  9'd0,   8'hFF, '{8'h00, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_OID_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_OID_LAST, 64'hC3, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd211, 8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd219, 8'h00, '0},
        // raw payload at the tail of the largest message, oid length ignored
        '{ROW_CFG, CFG_DER_MODE, 64'd0, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_EM_LEN, 64'd512, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_PL_LEN, 64'd64, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_OID_LEN, 64'd15, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd511, 8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd447, 8'h00, '0},
        '{ROW_CFG, CFG_EM_LEN, 64'd0, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_CMP,  9'd0,   8'h00, '{8'h00, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_EM_LEN, 64'd1023, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd5,   8'h00, '{8'h00, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_EM_LEN, 64'd100, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_PL_LEN, 64'd127, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd1,   8'h00, '{8'h00, 1'b0, 1'b1}},
        // digest info with oid length past nine
        '{ROW_CFG, CFG_PL_LEN, 64'd0, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_DER_MODE, 64'd1, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd1,   8'h00, '{8'h00, 1'b0, 1'b1}},
        // zero padding run: separator right after the block type
        '{ROW_CFG, CFG_OID_LEN, 64'd0, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_CFG, CFG_EM_LEN, 64'd13, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_CMP,  9'd0,   8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd2,   8'h00, '0},
        '{ROW_REQ,       CFG_EM_LEN, 64'd0, CMD_READ, 9'd12,  8'h00, '0},
        '{ROW_CFG, CFG_EM_LEN, 64'd12, CMD_NONE, 9'd0, 8'h00, '0},
        '{ROW_REQ_TYPED, CFG_EM_LEN, 64'd0, CMD_READ, 9'd0,   8'h00, '{8'h00, 1'b1, 1'b1}}
    };

    initial begin
        t_cfg       cfg;
        t_cmd       cmd;
        bit         bad;
        int         corrupt_pct;
        int         d;
        int         idx;
        int         n;
        int         top;
        int         stall_choice [3];

        stall_choice = '{0, 5, 25};

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_EM_LEN;
        i_cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= CMD_NONE;
        in_ch.index <= '0;
        in_ch.data  <= '0;

        pred_cfg.em_len          = EM_LEN_W'(256);
        pred_cfg.der_mode        = 1'b1;
        pred_cfg.payload_len     = PL_LEN_W'(32);
        pred_cfg.oid_len         = OID_LEN_W'(OID_MAX);
        pred_cfg.oid_first_bytes = '0;
        pred_cfg.oid_last_byte   = '0;
        pred_match               = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole payload store so no read ever hits an unwritten entry
        gap_pct   = 10;
        stall_pct = 10;
        for (int k = 0; k < MAX_PAYLOAD; k++)
            send_request(CMD_LOAD, k, (k == 0) ? 8'hA5 : $urandom_range(0, 255), 1'b0, '0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                drain_results();
                set_register(directed_rows[r].reg_idx, directed_rows[r].reg_val);
                i_cfg_we <= 1'b0;
            end else begin
                send_request(directed_rows[r].cmd, int'(directed_rows[r].index),
                             int'(directed_rows[r].data),
                             directed_rows[r].kind == ROW_REQ_TYPED, directed_rows[r].res);
            end
        end

        while (n_items < ITEM_TARGET) begin
            if (n_items > ITEM_TARGET - QUIET_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = stall_choice[$urandom_range(0, 2)];
                stall_pct = stall_choice[$urandom_range(0, 2)];
            end
            bad = ($urandom_range(0, 99) < 15);
            cfg = pick_config(bad);
            drain_results();
            write_all_registers(cfg);
            n_phases++;
            if (bad)
                n_bad_phases++;

            n = $urandom_range(0, 6);
            repeat (n)
                send_request(CMD_LOAD, $urandom_range(0, MAX_PAYLOAD - 1), $urandom_range(0, 255),
                             1'b0, '0);

            case (bad ? 9 : $urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // full compare pass over the message, sometimes with corrupted bytes
                    corrupt_pct = ($urandom_range(0, 2) == 0) ? 3 : 0;
                    for (int p = 0; p < int'(pred_cfg.em_len); p++) begin
                        d = int'(encoded_byte_at(p));
                        if (corrupt_pct != 0 && $urandom_range(0, 99) < corrupt_pct)
                            d = d ^ $urandom_range(1, 255);
                        send_request(CMD_CMP, p, d, 1'b0, '0);
                    end
                    if (pred_match)
                        n_clean_sweeps++;
                    if ($urandom_range(0, 1) == 0)
                        send_request(CMD_CMP, $urandom_range(int'(pred_cfg.em_len), 511),
                                     $urandom_range(0, 255), 1'b0, '0);
                end
                5, 6: begin
                    for (int p = 0; p < int'(pred_cfg.em_len); p++)
                        send_request(CMD_READ, p, $urandom_range(0, 255), 1'b0, '0);
                end
                default: begin
                    top = (int'(pred_cfg.em_len) + 4 > 511) ? 511 : int'(pred_cfg.em_len) + 4;
                    n = $urandom_range(20, 50);
                    repeat (n) begin
                        d = $urandom_range(0, 99);
                        if (d < 25)
                            cmd = CMD_LOAD;
                        else if (d < 55)
                            cmd = CMD_READ;
                        else if (d < 90)
                            cmd = CMD_CMP;
                        else
                            cmd = CMD_NONE;
                        if (cmd == CMD_LOAD)
                            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 127);
                        else
                            idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, top)
                                                             : $urandom_range(0, 511);
                        d = $urandom_range(0, 255);
                        if (cmd == CMD_CMP && $urandom_range(0, 1) == 0 && !config_unusable()
                            && idx < int'(pred_cfg.em_len))
                            d = int'(encoded_byte_at(idx));
                        send_request(cmd, idx, d, 1'b0, '0);
                    end
                end
            endcase
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests over %0d register settings (%0d with a length error), %0d results",
                 n_items, n_phases, n_bad_phases, n_results);
        $display("%0d full compare passes ended with all bytes matched", n_clean_sweeps);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/pkcs1_pkg.sv
hw/rtl/pkcs1_in_if.sv
hw/rtl/pkcs1_out_if.sv
hw/rtl/pkcs1_ram.sv
hw/rtl/pkcs1_expect.sv
hw/rtl/pkcs1_v15_signature_padding_core.sv
test/pkcs1_v15_signature_padding_core_test.sv
